FILE: src/steq_pkg.sv
// Types, constants and codes shared by the sorted timer event queue.
package steq_pkg;

  localparam int unsigned IDX_W  = 5;
  localparam int unsigned DEPTH  = 1 << IDX_W;
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned ACT_W  = 2;

  localparam logic [TIME_W-1:0] WAIT_FLOOR = TIME_W'(1000000);

  localparam logic [ACT_W-1:0] ACT_REL    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ABS    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_PROC   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_GRANT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WAIT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd5;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] delay_us;
    logic [TAG_W-1:0]  event_tag;
    logic [IDX_W-1:0]  slot_handle;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  fired_tag;
    logic [IDX_W-1:0]  granted_handle;
    logic [TIME_W-1:0] wait_us;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic             set;
    logic [IDX_W-1:0] set_idx;
    logic             clr;
    logic [IDX_W-1:0] clr_idx;
  } alloc_req_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_I_RD  = 10'b0000000010,
    S_I_DR  = 10'b0000000100,
    S_I_CMP = 10'b0000001000,
    S_C_RD  = 10'b0000010000,
    S_C_CHK = 10'b0000100000,
    S_P_RD  = 10'b0001000000,
    S_P_DR  = 10'b0010000000,
    S_P_CMP = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

endpackage

FILE: src/steq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module steq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/steq_alloc.sv
// Slot occupancy flags and lowest free slot search.
module steq_alloc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  steq_pkg::alloc_req_t      req_i,
  output logic [steq_pkg::DEPTH-1:0] in_use_o,
  output logic [steq_pkg::IDX_W-1:0] free_idx_o
);
  import steq_pkg::*;

  logic [DEPTH-1:0] in_use_q, in_use_d;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    in_use_d = in_use_q;
    if (req_i.clr) begin
      in_use_d[req_i.clr_idx] = 1'b0;
    end
    if (req_i.set) begin
      in_use_d[req_i.set_idx] = 1'b1;
    end
  end

  always_comb begin
    free_idx = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        free_idx = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

  assign in_use_o   = in_use_q;
  assign free_idx_o = free_idx;

endmodule

FILE: src/sorted_timer_event_queue_top.sv
// Sorted timer event queue: control sequencer, order list and entry stores.
//
// Input channel in_valid_i / in_stall_o carries one request item; output
// channel out_valid_o / out_stall_i carries result items, the final one of
// each request marked by last. One request is worked at a time; in_stall_o
// stays high from acceptance until its final result is taken.
// Schedule walks back one entry at a time from the tail of the order list.
// Cancel walks every listed entry. Process pops each expired entry from the
// head. Each result passes through the output register. Schedule and process
// read the order list RAM through its single read port, followed by the
// deadline RAM read.
// The order list is a ring with a head pointer, so popping costs no shift.
// Reset clears the occupancy flags, entry count and head pointer at once;
// the RAMs need no clearing and the block accepts items right after reset.
// A stalled result holds in the output register and the sequencer waits.
module sorted_timer_event_queue_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  steq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output steq_pkg::out_item_t out_item_o
);
  import steq_pkg::*;

  localparam int unsigned ENT_W = TAG_W + TIME_W;

  state_e state_q, state_d, ret_q, ret_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic found_q, found_d;
  logic [IDX_W-1:0] prev_q, prev_d, slot_q, slot_d, hdl_q, hdl_d;
  logic [TIME_W-1:0] dl_q, dl_d, now_q, now_d;

  logic ord_we;
  logic [IDX_W-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic dst_we;
  logic [IDX_W-1:0] dst_waddr, dst_raddr;
  logic [ENT_W-1:0] dst_wdata, dst_rdata;
  alloc_req_t areq;
  logic [DEPTH-1:0] in_use;
  logic [IDX_W-1:0] free_idx;

  logic [TIME_W:0] sum;
  logic [TIME_W-1:0] new_dl, rd_dl, wait_v;
  logic [IDX_W-1:0] idx_lo;

  assign sum    = {1'b0, in_item_i.now_us} + {1'b0, in_item_i.delay_us};
  assign new_dl = (in_item_i.action == ACT_REL)
                ? (sum[TIME_W] ? '1 : sum[TIME_W-1:0]) : in_item_i.delay_us;
  assign rd_dl  = dst_rdata[TIME_W-1:0];
  assign wait_v = (rd_dl - now_q == '0) ? WAIT_FLOOR : rd_dl - now_q;
  assign idx_lo = idx_q[IDX_W-1:0];

  steq_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_order (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  steq_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_entry (
    .clk_i   (clk_i),
    .we_i    (dst_we),
    .waddr_i (dst_waddr),
    .wdata_i (dst_wdata),
    .raddr_i (dst_raddr),
    .rdata_o (dst_rdata)
  );

  steq_alloc u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (areq),
    .in_use_o   (in_use),
    .free_idx_o (free_idx)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    found_d     = found_q;
    prev_d      = prev_q;
    slot_d      = slot_q;
    hdl_d       = hdl_q;
    dl_d        = dl_q;
    now_d       = now_q;
    ord_we      = 1'b0;
    ord_waddr   = head_q + idx_lo;
    ord_wdata   = slot_q;
    ord_raddr   = head_q;
    dst_we      = 1'b0;
    dst_waddr   = free_idx;
    dst_wdata   = {in_item_i.event_tag, new_dl};
    dst_raddr   = ord_rdata;
    areq        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.action)
            ACT_REL, ACT_ABS: begin
              if (count_q == CNT_W'(DEPTH)) begin
                out_d       = '{kind: KIND_FULL, last: 1'b1, default: '0};
                out_valid_d = 1'b1;
                ret_d       = S_IDLE;
                state_d     = S_OUT;
              end else begin
                dst_we       = 1'b1;
                areq.set     = 1'b1;
                areq.set_idx = free_idx;
                slot_d       = free_idx;
                dl_d         = new_dl;
                idx_d        = count_q;
                state_d      = S_I_RD;
              end
            end
            ACT_CANCEL: begin
              hdl_d = in_item_i.slot_handle;
              if (in_use[in_item_i.slot_handle]) begin
                areq.clr     = 1'b1;
                areq.clr_idx = in_item_i.slot_handle;
                idx_d        = '0;
                found_d      = 1'b0;
                state_d      = S_C_RD;
              end else begin
                out_d       = '{kind: KIND_DONE, last: 1'b1, default: '0};
                out_valid_d = 1'b1;
                ret_d       = S_IDLE;
                state_d     = S_OUT;
              end
            end
            default: begin
              now_d   = in_item_i.now_us;
              state_d = S_P_RD;
            end
          endcase
        end
      end
      S_I_RD: begin
        if (idx_q == '0) begin
          ord_we      = 1'b1;
          count_d     = count_q + CNT_W'(1);
          out_d       = '{kind: KIND_GRANT, granted_handle: slot_q, last: 1'b1,
                          default: '0};
          out_valid_d = 1'b1;
          ret_d       = S_IDLE;
          state_d     = S_OUT;
        end else begin
          ord_raddr = head_q + idx_lo - IDX_W'(1);
          state_d   = S_I_DR;
        end
      end
      S_I_DR: begin
        prev_d  = ord_rdata;
        state_d = S_I_CMP;
      end
      S_I_CMP: begin
        ord_we = 1'b1;
        if (rd_dl > dl_q) begin
          ord_wdata = prev_q;
          idx_d     = idx_q - CNT_W'(1);
          state_d   = S_I_RD;
        end else begin
          count_d     = count_q + CNT_W'(1);
          out_d       = '{kind: KIND_GRANT, granted_handle: slot_q, last: 1'b1,
                          default: '0};
          out_valid_d = 1'b1;
          ret_d       = S_IDLE;
          state_d     = S_OUT;
        end
      end
      S_C_RD: begin
        if (idx_q == count_q) begin
          if (found_q) begin
            count_d = count_q - CNT_W'(1);
          end
          out_d       = '{kind: KIND_DONE, last: 1'b1, default: '0};
          out_valid_d = 1'b1;
          ret_d       = S_IDLE;
          state_d     = S_OUT;
        end else begin
          ord_raddr = head_q + idx_lo;
          state_d   = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (found_q) begin
          ord_we    = 1'b1;
          ord_waddr = head_q + idx_lo - IDX_W'(1);
          ord_wdata = ord_rdata;
        end else if (ord_rdata == hdl_q) begin
          found_d = 1'b1;
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_C_RD;
      end
      S_P_RD: begin
        if (count_q == '0) begin
          out_d       = '{kind: KIND_EMPTY, last: 1'b1, default: '0};
          out_valid_d = 1'b1;
          ret_d       = S_IDLE;
          state_d     = S_OUT;
        end else begin
          ord_raddr = head_q;
          state_d   = S_P_DR;
        end
      end
      S_P_DR: begin
        slot_d  = ord_rdata;
        state_d = S_P_CMP;
      end
      S_P_CMP: begin
        out_valid_d = 1'b1;
        state_d     = S_OUT;
        if (rd_dl <= now_q) begin
          areq.clr     = 1'b1;
          areq.clr_idx = slot_q;
          head_d       = head_q + IDX_W'(1);
          count_d      = count_q - CNT_W'(1);
          out_d        = '{kind: KIND_FIRED, fired_tag: dst_rdata[TIME_W +: TAG_W],
                           default: '0};
          ret_d        = S_P_RD;
        end else begin
          out_d = '{kind: KIND_WAIT, wait_us: wait_v, last: 1'b1, default: '0};
          ret_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    prev_q <= prev_d;
    slot_q <= slot_d;
    hdl_q  <= hdl_d;
    dl_q   <= dl_d;
    now_q  <= now_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_count_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(in_use) == int'(count_q)))
    else $error("occupancy flags disagree with entry count");

  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OUT))
    else $error("result shown outside output state");

  a_grant_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_q.kind == KIND_GRANT) |-> out_q.last)
    else $error("handle grant not marked last");

  a_fired_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_q.kind == KIND_FIRED) |-> (ret_q == S_P_RD))
    else $error("expired item does not continue the pop walk");

endmodule
